[hdl/xoshiro256ss_random_generator_unit_defines.svh]
// Assertion macros for the RTL of the random generator.
`ifndef XOSHIRO256SS_RANDOM_GENERATOR_UNIT_DEFINES_SVH
`define XOSHIRO256SS_RANDOM_GENERATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XRNG_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xrng check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define XRNG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xrng check failed in the next cycle");

`endif

[hdl/xrng_pkg.sv]
`default_nettype none

package xrng_pkg;

   localparam int unsigned WORD_W = 64;
   localparam int unsigned HALF_W = WORD_W / 2;
   localparam int unsigned STATE_WORDS = 4;
   localparam int unsigned IDX_W = $clog2(STATE_WORDS);

   localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
   localparam logic [WORD_W-1:0] MIX_MUL_A = 64'hBF58476D1CE4E5B9;
   localparam logic [WORD_W-1:0] MIX_MUL_B = 64'h94D049BB133111EB;

   localparam int unsigned MIX_SHIFT_A = 30;
   localparam int unsigned MIX_SHIFT_B = 27;
   localparam int unsigned MIX_SHIFT_C = 31;
   localparam int unsigned XS_SHIFT = 17;
   localparam int unsigned XS_ROT = 45;
   localparam int unsigned OUT_ROT = 7;

   typedef enum logic [1:0] {
      REQ_NEXT = 2'd0,
      REQ_SEED = 2'd1,
      REQ_SEED_DEFAULT = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX_ADD,
      ST_MUL_A,
      ST_MUL_B,
      ST_NEXT_A,
      ST_NEXT_B
   } state_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] product;
   } mul_rsp_type;

   function automatic logic [WORD_W-1:0] rot_left(input logic [WORD_W-1:0] v,
                                                  input int unsigned amt);
      logic [WORD_W-1:0] r;
      r = (v << amt) | (v >> (WORD_W - amt));
      return r;
   endfunction

endpackage

`default_nettype wire

[hdl/xrng_if.sv]
`default_nettype none

interface xrng_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [63:0] seed_value;

   modport source (output valid, output req_type, output seed_value, input ready);
   modport sink (input valid, input req_type, input seed_value, output ready);
endinterface

interface xrng_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] random_word;

   modport source (output valid, output random_word, input ready);
   modport sink (input valid, input random_word, output ready);
endinterface

interface xrng_csr_if;
   logic        valid;
   logic        ready;
   logic [63:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/xrng_mul.sv]
`default_nettype none

module xrng_mul (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire xrng_pkg::mul_req_type req,
   output xrng_pkg::mul_rsp_type      rsp
);

   logic [xrng_pkg::WORD_W-1:0] a_ff, a_in;
   logic [xrng_pkg::WORD_W-1:0] b_ff, b_in;
   logic [xrng_pkg::WORD_W-1:0] prod_ff, prod_in;
   logic [xrng_pkg::WORD_W-1:0] acc_ff, acc_in;
   logic [1:0]                  step_ff, step_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [xrng_pkg::HALF_W-1:0] op_a, op_b;

   // Low word of a 64 by 64 product from three 32 by 32 partial products.
   always_comb begin
      unique case (step_ff)
         2'd0: begin
            op_a = a_ff[xrng_pkg::HALF_W-1:0];
            op_b = b_ff[xrng_pkg::HALF_W-1:0];
         end
         2'd1: begin
            op_a = a_ff[xrng_pkg::HALF_W-1:0];
            op_b = b_ff[xrng_pkg::WORD_W-1:xrng_pkg::HALF_W];
         end
         2'd2: begin
            op_a = a_ff[xrng_pkg::WORD_W-1:xrng_pkg::HALF_W];
            op_b = b_ff[xrng_pkg::HALF_W-1:0];
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      acc_in = acc_ff;
      prod_in = {{xrng_pkg::HALF_W{1'b0}}, op_a} * {{xrng_pkg::HALF_W{1'b0}}, op_b};
      done_in = busy_ff && (step_ff == 2'd3);
      if (req.start) begin
         a_in = req.a;
         b_in = req.b;
         step_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            busy_in = 1'b0;
         end
      end
      if (busy_ff) begin
         priority if (step_ff == 2'd1) begin
            acc_in = prod_ff;
         end else if (step_ff != 2'd0) begin
            acc_in[xrng_pkg::WORD_W-1:xrng_pkg::HALF_W] =
               acc_ff[xrng_pkg::WORD_W-1:xrng_pkg::HALF_W] +
               prod_ff[xrng_pkg::HALF_W-1:0];
         end else begin
            acc_in = acc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.product = acc_ff;

endmodule

`default_nettype wire

[hdl/xoshiro256ss_random_generator_unit.sv]
// A next word moves through NEXT_A and NEXT_B to a registered result, NEXT_B waiting while an
// untaken word holds the output; a new request is taken only in idle. Seeding runs four
// splitmix64 steps through one shared 32x32 multiplier, one step per state word, so a seed request
// keeps the block busy, giving no result. An unseeded next word first seeds from the default seed.
// Synchronous active-high reset clears the seeded flag, the default seed and the handshakes.
`default_nettype none
`include "xoshiro256ss_random_generator_unit_defines.svh"

module xoshiro256ss_random_generator_unit (
   input wire logic    clock,
   input wire logic    reset,
   xrng_req_if.sink    req_port,
   xrng_rsp_if.source  rsp_port,
   xrng_csr_if.sink    csr_port
);

   typedef struct packed {
      logic req_ready;
      logic mix_add;
      logic wait_a;
      logic wait_b;
      logic next_a;
      logic next_b;
   } ctrl_type;

   xrng_pkg::state_type state_ff, state_in;
   ctrl_type            ctrl;

   logic [xrng_pkg::WORD_W-1:0] gen_state_ff [xrng_pkg::STATE_WORDS];
   logic [xrng_pkg::WORD_W-1:0] gen_state_in [xrng_pkg::STATE_WORDS];
   logic [xrng_pkg::WORD_W-1:0] default_seed_ff, default_seed_in;
   logic [xrng_pkg::WORD_W-1:0] walker_ff, walker_in;
   logic [xrng_pkg::WORD_W-1:0] tmp_ff, tmp_in;
   logic [xrng_pkg::WORD_W-1:0] word_ff, word_in;
   logic [xrng_pkg::IDX_W-1:0]  seed_idx_ff, seed_idx_in;
   logic                        seeded_ff, seeded_in;
   logic                        pend_next_ff, pend_next_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        req_go, out_free, word_store, last_word, seed_load;
   logic [xrng_pkg::WORD_W-1:0] walker_sum, mix_z, mix_y, mix_out, seed_src;
   logic [xrng_pkg::WORD_W-1:0] t2, t3;

   xrng_pkg::mul_req_type mul_req;
   xrng_pkg::mul_rsp_type mul_rsp;

   xrng_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   assign req_go = req_port.valid && ctrl.req_ready;
   assign out_free = !rsp_valid_ff || rsp_port.ready;
   assign word_store = ctrl.wait_b && mul_rsp.done;
   assign last_word = (seed_idx_ff == xrng_pkg::IDX_W'(xrng_pkg::STATE_WORDS - 1));
   assign seed_load = req_go && (req_port.req_type == xrng_pkg::REQ_SEED
      || req_port.req_type == xrng_pkg::REQ_SEED_DEFAULT
      || (req_port.req_type == xrng_pkg::REQ_NEXT && !seeded_ff));
   assign seed_src = (req_port.req_type == xrng_pkg::REQ_SEED) ? req_port.seed_value
                                                              : default_seed_ff;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         xrng_pkg::ST_IDLE: begin
            if (req_go) begin
               unique case (req_port.req_type)
                  xrng_pkg::REQ_NEXT: begin
                     state_in = seeded_ff ? xrng_pkg::ST_NEXT_A : xrng_pkg::ST_MIX_ADD;
                  end
                  xrng_pkg::REQ_SEED, xrng_pkg::REQ_SEED_DEFAULT: begin
                     state_in = xrng_pkg::ST_MIX_ADD;
                  end
                  default: begin
                     state_in = xrng_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         xrng_pkg::ST_MIX_ADD: begin
            state_in = xrng_pkg::ST_MUL_A;
         end
         xrng_pkg::ST_MUL_A: begin
            if (mul_rsp.done) begin
               state_in = xrng_pkg::ST_MUL_B;
            end
         end
         xrng_pkg::ST_MUL_B: begin
            if (mul_rsp.done) begin
               priority if (!last_word) begin
                  state_in = xrng_pkg::ST_MIX_ADD;
               end else if (pend_next_ff) begin
                  state_in = xrng_pkg::ST_NEXT_A;
               end else begin
                  state_in = xrng_pkg::ST_IDLE;
               end
            end
         end
         xrng_pkg::ST_NEXT_A: begin
            state_in = xrng_pkg::ST_NEXT_B;
         end
         xrng_pkg::ST_NEXT_B: begin
            if (out_free) begin
               state_in = xrng_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = xrng_pkg::ST_IDLE;
         end
      endcase
   end

   // Output decode.
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         xrng_pkg::ST_IDLE:    ctrl.req_ready = 1'b1;
         xrng_pkg::ST_MIX_ADD: ctrl.mix_add = 1'b1;
         xrng_pkg::ST_MUL_A:   ctrl.wait_a = 1'b1;
         xrng_pkg::ST_MUL_B:   ctrl.wait_b = 1'b1;
         xrng_pkg::ST_NEXT_A:  ctrl.next_a = 1'b1;
         xrng_pkg::ST_NEXT_B:  ctrl.next_b = 1'b1;
         default:              ctrl = '0;
      endcase
   end

   // Splitmix64 step, with the multiplies done by the shared unit.
   assign walker_sum = walker_ff + xrng_pkg::GOLDEN_GAMMA;
   assign mix_z = walker_sum ^ (walker_sum >> xrng_pkg::MIX_SHIFT_A);
   assign mix_y = mul_rsp.product ^ (mul_rsp.product >> xrng_pkg::MIX_SHIFT_B);
   assign mix_out = mul_rsp.product ^ (mul_rsp.product >> xrng_pkg::MIX_SHIFT_C);

   assign mul_req.start = ctrl.mix_add || (ctrl.wait_a && mul_rsp.done);
   assign mul_req.a = ctrl.mix_add ? mix_z : mix_y;
   assign mul_req.b = ctrl.mix_add ? xrng_pkg::MIX_MUL_A : xrng_pkg::MIX_MUL_B;

   assign t2 = gen_state_ff[2] ^ gen_state_ff[0];
   assign t3 = gen_state_ff[3] ^ gen_state_ff[1];

   always_comb begin
      gen_state_in = gen_state_ff;
      default_seed_in = default_seed_ff;
      walker_in = walker_ff;
      tmp_in = tmp_ff;
      word_in = word_ff;
      seed_idx_in = seed_idx_ff;
      seeded_in = seeded_ff;
      pend_next_in = pend_next_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;

      if (csr_port.valid) begin
         default_seed_in = csr_port.data;
      end
      if (seed_load) begin
         walker_in = seed_src;
         seed_idx_in = '0;
         pend_next_in = (req_port.req_type == xrng_pkg::REQ_NEXT);
      end else if (ctrl.mix_add) begin
         walker_in = walker_sum;
      end
      if (word_store) begin
         gen_state_in[seed_idx_ff] = mix_out;
         seed_idx_in = seed_idx_ff + 1'b1;
         if (last_word) begin
            seeded_in = 1'b1;
         end
      end
      if (ctrl.next_a) begin
         pend_next_in = 1'b0;
         tmp_in = xrng_pkg::rot_left(gen_state_ff[1] + (gen_state_ff[1] << 2),
                                     xrng_pkg::OUT_ROT);
      end
      if (ctrl.next_b && out_free) begin
         word_in = tmp_ff + (tmp_ff << 3);
         rsp_valid_in = 1'b1;
         gen_state_in[0] = gen_state_ff[0] ^ t3;
         gen_state_in[1] = gen_state_ff[1] ^ t2;
         gen_state_in[2] = t2 ^ (gen_state_ff[1] << xrng_pkg::XS_SHIFT);
         gen_state_in[3] = xrng_pkg::rot_left(t3, xrng_pkg::XS_ROT);
      end
   end

   always_ff @(posedge clock) begin
      gen_state_ff <= gen_state_in;
      walker_ff <= walker_in;
      tmp_ff <= tmp_in;
      word_ff <= word_in;
      if (reset) begin
         state_ff <= xrng_pkg::ST_IDLE;
         default_seed_ff <= '0;
         seed_idx_ff <= '0;
         seeded_ff <= 1'b0;
         pend_next_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         default_seed_ff <= default_seed_in;
         seed_idx_ff <= seed_idx_in;
         seeded_ff <= seeded_in;
         pend_next_ff <= pend_next_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_port.ready = ctrl.req_ready;
   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.random_word = word_ff;
   assign csr_port.ready = 1'b1;

   `XRNG_ASSERT_SAME(a_next_needs_seed, clock, reset,
      state_ff == xrng_pkg::ST_NEXT_A, seeded_ff)
   `XRNG_ASSERT_NEXT(a_word_sets_valid, clock, reset,
      state_ff == xrng_pkg::ST_NEXT_B && out_free, rsp_valid_ff)
   `XRNG_ASSERT_SAME(a_done_while_waiting, clock, reset,
      mul_rsp.done, state_ff == xrng_pkg::ST_MUL_A || state_ff == xrng_pkg::ST_MUL_B)
   `XRNG_ASSERT_SAME(a_idle_index_clear, clock, reset,
      state_ff == xrng_pkg::ST_IDLE, seed_idx_ff == '0)

endmodule

`default_nettype wire

[dv/xrng_word_checker.sv]
`timescale 1ns / 1ps

module xrng_word_checker (
   input  logic clock,
   input  logic reset,
   xrng_req_if  req_mon,
   xrng_rsp_if  rsp_mon,
   xrng_csr_if  csr_mon,
   output int   fail_count,
   output int   pending_words,
   output int   words_checked
);

   logic [xrng_pkg::WORD_W-1:0] gen_words [xrng_pkg::STATE_WORDS];
   logic                        gen_seeded;
   logic [xrng_pkg::WORD_W-1:0] seed_reg;
   logic [xrng_pkg::WORD_W-1:0] expected_words [$];

   function automatic logic [xrng_pkg::WORD_W-1:0] splitmix_draw(
      inout logic [xrng_pkg::WORD_W-1:0] walker);
      logic [xrng_pkg::WORD_W-1:0] z;
      walker = walker + xrng_pkg::GOLDEN_GAMMA;
      z = walker;
      z = (z ^ (z >> xrng_pkg::MIX_SHIFT_A)) * xrng_pkg::MIX_MUL_A;
      z = (z ^ (z >> xrng_pkg::MIX_SHIFT_B)) * xrng_pkg::MIX_MUL_B;
      return z ^ (z >> xrng_pkg::MIX_SHIFT_C);
   endfunction

   function automatic void spread_seed(input logic [xrng_pkg::WORD_W-1:0] seed);
      logic [xrng_pkg::WORD_W-1:0] walker;
      walker = seed;
      for (int i = 0; i < xrng_pkg::STATE_WORDS; i++) begin
         gen_words[i] = splitmix_draw(walker);
      end
      gen_seeded = 1'b1;
   endfunction

   function automatic logic [xrng_pkg::WORD_W-1:0] xoshiro_draw();
      logic [xrng_pkg::WORD_W-1:0] scaled;
      logic [xrng_pkg::WORD_W-1:0] word;
      logic [xrng_pkg::WORD_W-1:0] shifted;
      scaled = gen_words[1] * 5;
      word = {scaled[56:0], scaled[63:57]} * 9;
      shifted = gen_words[1] << xrng_pkg::XS_SHIFT;
      gen_words[2] = gen_words[2] ^ gen_words[0];
      gen_words[3] = gen_words[3] ^ gen_words[1];
      gen_words[1] = gen_words[1] ^ gen_words[2];
      gen_words[0] = gen_words[0] ^ gen_words[3];
      gen_words[2] = gen_words[2] ^ shifted;
      gen_words[3] = {gen_words[3][18:0], gen_words[3][63:19]};
      return word;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < xrng_pkg::STATE_WORDS; i++) begin
            gen_words[i] = '0;
         end
         gen_seeded = 1'b0;
         seed_reg = '0;
         expected_words.delete();
         fail_count = 0;
         words_checked = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            seed_reg = csr_mon.data;
         end
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.req_type)
               xrng_pkg::REQ_SEED: begin
                  spread_seed(req_mon.seed_value);
               end
               xrng_pkg::REQ_SEED_DEFAULT: begin
                  spread_seed(seed_reg);
               end
               xrng_pkg::REQ_NEXT: begin
                  if (!gen_seeded) begin
                     spread_seed(seed_reg);
                  end
                  expected_words.push_back(xoshiro_draw());
               end
               default: begin
               end
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_words.size() == 0) begin
               $error("random_word: expected no word, actual %h", rsp_mon.random_word);
               fail_count++;
            end else begin
               if (rsp_mon.random_word !== expected_words[0]) begin
                  $error("random_word: expected %h, actual %h",
                         expected_words[0], rsp_mon.random_word);
                  fail_count++;
               end
               void'(expected_words.pop_front());
               words_checked++;
            end
         end
      end
      pending_words = expected_words.size();
   end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;
   localparam int SETTLE_CYCLES = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int fail_count;
   int pending_words;
   int words_checked;
   int rx_hold = 0;
   bit tx_calm = 1'b0;
   int n_next = 0;
   int n_seed = 0;
   int n_dflt = 0;
   int n_unused = 0;
   int n_csr = 0;

   xrng_req_if req_if();
   xrng_rsp_if rsp_if();
   xrng_csr_if csr_if();

   xoshiro256ss_random_generator_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   xrng_word_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .csr_mon       (csr_if),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .words_checked (words_checked)
   );

   always #4 clock = ~clock;

   task automatic send_req(input logic [1:0] code, input logic [63:0] seed);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.req_type <= code;
      req_if.seed_value <= seed;
      do @(posedge clock); while (!req_if.ready);
      case (code)
         xrng_pkg::REQ_NEXT: n_next++;
         xrng_pkg::REQ_SEED: n_seed++;
         xrng_pkg::REQ_SEED_DEFAULT: n_dflt++;
         default: n_unused++;
      endcase
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      wait (pending_words == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_default_seed(input logic [63:0] value);
      settle();
      csr_if.valid <= 1'b1;
      csr_if.data <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      n_csr++;
   endtask

   task automatic run_random(input int count);
      int accepted;
      int pick;
      logic [1:0] code;
      logic [63:0] seed;
      accepted = 0;
      while (accepted < count) begin
         if (accepted % 64 == 0) begin
            tx_calm = ($urandom_range(0, 3) == 0);
         end
         pick = $urandom_range(0, 99);
         seed = {$urandom, $urandom};
         if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 3))
               0: seed = '0;
               1: seed = ALL_ONES;
               2: seed = 64'd1;
               default: seed = TOP_BIT;
            endcase
         end
         if (pick < 82) begin
            code = xrng_pkg::REQ_NEXT;
         end else if (pick < 90) begin
            code = xrng_pkg::REQ_SEED;
         end else if (pick < 96) begin
            code = xrng_pkg::REQ_SEED_DEFAULT;
         end else begin
            code = REQ_UNUSED;
         end
         send_req(code, seed);
         if (code != REQ_UNUSED) begin
            accepted++;
         end
      end
   endtask

   initial begin : rsp_side
      int stall;
      int taken;
      bit rx_calm;
      taken = 0;
      rx_calm = 1'b0;
      rsp_if.ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (taken % 64 == 0) begin
            rx_calm = ($urandom_range(0, 3) == 0);
         end
         stall = rx_calm ? 0 : $urandom_range(0, 17);
         if (rx_hold > 0) begin
            stall = rx_hold;
            rx_hold = 0;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         taken++;
      end
   end

   initial begin : watchdog
      #8_000_000;
      $display("FAIL xoshiro256ss_random_generator_unit");
      $finish;
   end

   initial begin : stimulus
      logic [63:0] settings [6];
      settings[0] = ALL_ONES;
      settings[1] = 64'd1;
      settings[2] = TOP_BIT;
      settings[3] = '0;
      settings[4] = {$urandom, $urandom};
      settings[5] = {$urandom, $urandom};

      req_if.valid <= 1'b0;
      req_if.req_type <= xrng_pkg::REQ_NEXT;
      req_if.seed_value <= '0;
      csr_if.valid <= 1'b0;
      csr_if.data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The first word comes from an unseeded generator and the reset default seed.
      send_req(xrng_pkg::REQ_NEXT, ALL_ONES);
      send_req(xrng_pkg::REQ_NEXT, '0);
      send_req(REQ_UNUSED, ALL_ONES);
      send_req(xrng_pkg::REQ_NEXT, TOP_BIT);
      send_req(xrng_pkg::REQ_SEED, '0);
      send_req(xrng_pkg::REQ_NEXT, '0);
      send_req(xrng_pkg::REQ_NEXT, ALL_ONES);
      send_req(xrng_pkg::REQ_SEED, ALL_ONES);
      send_req(xrng_pkg::REQ_NEXT, '0);
      send_req(xrng_pkg::REQ_SEED_DEFAULT, ALL_ONES);
      send_req(xrng_pkg::REQ_NEXT, '0);
      send_req(xrng_pkg::REQ_SEED, TOP_BIT);
      send_req(xrng_pkg::REQ_SEED, 64'd1);
      send_req(xrng_pkg::REQ_NEXT, '0);
      send_req(xrng_pkg::REQ_NEXT, '0);
      send_req(REQ_UNUSED, '0);
      send_req(xrng_pkg::REQ_NEXT, 64'h0123_4567_89AB_CDEF);
      write_default_seed(ALL_ONES);
      send_req(xrng_pkg::REQ_NEXT, '0);
      send_req(xrng_pkg::REQ_SEED_DEFAULT, '0);
      send_req(xrng_pkg::REQ_NEXT, '0);
      send_req(xrng_pkg::REQ_NEXT, '0);

      for (int p = 0; p < 6; p++) begin
         write_default_seed(settings[p]);
         if (p == 1) begin
            rx_hold = 400;
            tx_calm = 1'b1;
         end
         run_random(315);
      end

      settle();
      $display("Run covered %0d next, %0d seed, %0d default-seed and %0d unused requests",
               n_next, n_seed, n_dflt, n_unused);
      $display("across %0d default seed settings, with %0d words compared.",
               n_csr, words_checked);
      if (fail_count == 0 && pending_words == 0) begin
         $display("PASS xoshiro256ss_random_generator_unit");
      end else begin
         $display("FAIL xoshiro256ss_random_generator_unit");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+hdl
hdl/xrng_pkg.sv
hdl/xrng_if.sv
hdl/xrng_mul.sv
hdl/xoshiro256ss_random_generator_unit.sv
dv/xrng_word_checker.sv
dv/tb_top.sv
